/* design/wsrd_pkg.sv */
// Shared constants and types for the work-stealing range dispatcher.
`default_nettype none
package wsrd_pkg;
	localparam int TASK_BITS   = 24;
	localparam int MAX_WORKERS = 16;
	localparam int BURST       = 32;
	localparam int WID_BITS    = $clog2(MAX_WORKERS);
	localparam int CNT_BITS    = $clog2(MAX_WORKERS + 1);
	localparam int DIV_BITS    = TASK_BITS + 1;
	localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
	localparam int WORD_BITS   = 2 * TASK_BITS;

	typedef logic [TASK_BITS-1:0] task_t;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_REQ   = 1'b1;

	localparam logic CFG_NUM_WORKERS = 1'b0;
	localparam logic CFG_TOTAL_TASKS = 1'b1;

	localparam task_t BURST_W = TASK_BITS'(BURST);
endpackage
`default_nettype wire

/* design/wsrd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module wsrd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* design/wsrd_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module wsrd_div
	import wsrd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [DIV_BITS-1:0] dividend,
	input  wire logic [CNT_BITS-1:0] divisor,
	output logic                     done,
	output logic      [DIV_BITS-1:0] quotient
);
	logic                    busy_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [CNT_BITS-1:0]     rem_q;
	logic [DIV_BITS-1:0]     quo_q;
	logic [CNT_BITS:0]       sh;
	logic                    qbit;
	logic [CNT_BITS:0]       diff;

	always_comb begin
		sh   = {rem_q, quo_q[DIV_BITS-1]};
		qbit = (sh >= {1'b0, divisor});
		diff = sh - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_BITS'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[CNT_BITS-1:0] : sh[CNT_BITS-1:0];
			quo_q <= {quo_q[DIV_BITS-2:0], qbit};
		end
	end

	assign quotient = quo_q;
endmodule
`default_nettype wire

/* design/work_stealing_range_dispatcher_core.sv */
// Top level: task range dispatcher with per-worker queues held in one RAM.
// A request with work in its own range reads its queue entry, updates it and answers; a steal
// adds a scan of the queue RAM (one read per cycle), then write-back of the peer's entry.
// Start runs the share divider, makes 16 RAM writes, then responds.
// One transaction is in work at a time; the next is accepted while a result waits.
// Reset (arst_n low) empties every range, clears finished state, sets num_workers 1.
`default_nettype none
module work_stealing_range_dispatcher_core
	import wsrd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wen,
	input  wire logic                 cfg_index,
	input  wire logic [TASK_BITS-1:0] cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 cmd,
	input  wire logic [WID_BITS-1:0]  worker_id,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [TASK_BITS-1:0] range_start,
	output logic      [TASK_BITS-1:0] range_stop,
	output logic                      has_work,
	output logic                      from_peer,
	output logic      [WID_BITS-1:0]  peer_index,
	output logic                      quit
);
	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_FILL, S_OWN, S_SCAN, S_STEAL, S_RESP
	} state_t;

	state_t               state_q;
	logic [CNT_BITS-1:0]  nw_q;
	task_t                total_q;
	logic [MAX_WORKERS-1:0] vld_q;
	logic [MAX_WORKERS-1:0] flags_q;
	logic [CNT_BITS-1:0]  fcnt_q;
	logic [WID_BITS-1:0]  w_q;
	task_t                per_q;
	task_t                fb_q;
	logic [CNT_BITS-1:0]  fidx_q;
	logic [CNT_BITS-1:0]  ip_q;
	logic                 rd_vld_s1;
	logic [WID_BITS-1:0]  rd_addr_s1;
	logic [WID_BITS-1:0]  peer_q;
	task_t                pf_q;
	task_t                pb_q;
	task_t                r_start_q;
	task_t                r_stop_q;
	logic                 r_has_q;
	logic                 r_peer_q;
	logic [WID_BITS-1:0]  r_idx_q;
	logic                 r_quit_q;

	logic [CNT_BITS-1:0]  n_eff;
	logic                 ram_we;
	logic [WID_BITS-1:0]  ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [WID_BITS-1:0]  ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;
	task_t                rd_front;
	task_t                rd_back;
	logic [TASK_BITS:0]   fb_sum;
	task_t                fe;
	logic [TASK_BITS:0]   own_sum;
	task_t                own_new;
	logic                 own_has;
	logic [CNT_BITS-1:0]  fcnt_new;
	logic                 self_hit;
	logic                 qual;
	logic                 scan_end;
	task_t                st_b0;
	task_t                st_b;
	logic                 div_start;
	logic [DIV_BITS-1:0]  div_dvd;
	logic                 div_done;
	logic [DIV_BITS-1:0]  div_quo;
	logic                 out_free;

	always_comb begin
		if (nw_q == '0) begin
			n_eff = CNT_BITS'(1);
		end else if (nw_q > CNT_BITS'(MAX_WORKERS)) begin
			n_eff = CNT_BITS'(MAX_WORKERS);
		end else begin
			n_eff = nw_q;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid || out_ready;
	assign div_start = in_valid && in_ready && (cmd == CMD_START);
	assign div_dvd   = {1'b0, total_q} + DIV_BITS'(n_eff) - DIV_BITS'(1);

	wsrd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (n_eff),
		.done     (div_done),
		.quotient (div_quo)
	);

	wsrd_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAX_WORKERS)
	) u_queue_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		rd_front = vld_q[rd_addr_s1] ? ram_rdata[WORD_BITS-1:TASK_BITS] : '0;
		rd_back  = vld_q[rd_addr_s1] ? ram_rdata[TASK_BITS-1:0] : '0;

		fb_sum = {1'b0, fb_q} + {1'b0, per_q};
		fe     = (fb_sum > {1'b0, total_q}) ? total_q : fb_sum[TASK_BITS-1:0];

		own_sum = {1'b0, rd_front} + {1'b0, BURST_W};
		own_new = (own_sum > {1'b0, rd_back}) ? rd_back : own_sum[TASK_BITS-1:0];
		own_has = (rd_front < rd_back);
		fcnt_new = fcnt_q + CNT_BITS'(!flags_q[w_q]);

		self_hit = (rd_addr_s1 == w_q);
		qual     = (own_sum < {1'b0, rd_back});
		scan_end = rd_vld_s1 && ((!self_hit && qual) ||
			({1'b0, rd_addr_s1} == n_eff - CNT_BITS'(1)));

		st_b0 = (pb_q > BURST_W) ? pb_q - BURST_W : '0;
		st_b  = (st_b0 < pf_q) ? pf_q : st_b0;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				ram_re    = in_valid && (cmd == CMD_REQ);
				ram_raddr = worker_id;
			end
			S_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = fidx_q[WID_BITS-1:0];
				ram_wdata = (fidx_q < n_eff) ? {fb_q, fe} : '0;
			end
			S_OWN: begin
				ram_we    = own_has;
				ram_waddr = w_q;
				ram_wdata = {own_new, rd_back};
			end
			S_SCAN: begin
				ram_re    = (ip_q < n_eff);
				ram_raddr = ip_q[WID_BITS-1:0];
			end
			S_STEAL: begin
				ram_we    = 1'b1;
				ram_waddr = peer_q;
				ram_wdata = {pf_q, st_b};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			nw_q      <= CNT_BITS'(1);
			total_q   <= '0;
			vld_q     <= '0;
			flags_q   <= '0;
			fcnt_q    <= '0;
			rd_vld_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					CFG_NUM_WORKERS: nw_q    <= cfg_data[CNT_BITS-1:0];
					CFG_TOTAL_TASKS: total_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (out_valid && out_ready && state_q != S_RESP) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						w_q      <= worker_id;
						r_start_q <= '0;
						r_stop_q  <= '0;
						r_has_q   <= 1'b0;
						r_peer_q  <= 1'b0;
						r_idx_q   <= '0;
						r_quit_q  <= (cmd == CMD_REQ) && ({1'b0, worker_id} >= n_eff);
						if (cmd == CMD_START) begin
							state_q <= S_DIV;
						end else if ({1'b0, worker_id} >= n_eff) begin
							state_q  <= S_RESP;
						end else begin
							state_q <= S_OWN;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						per_q   <= div_quo[TASK_BITS-1:0];
						fb_q    <= '0;
						fidx_q  <= '0;
						flags_q <= '0;
						fcnt_q  <= '0;
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					fb_q   <= fe;
					fidx_q <= fidx_q + 1'b1;
					if (fidx_q == CNT_BITS'(MAX_WORKERS - 1)) begin
						state_q <= S_RESP;
					end
				end
				S_OWN: begin
					if (own_has) begin
						r_start_q <= rd_front;
						r_stop_q  <= own_new;
						r_has_q   <= 1'b1;
						state_q   <= S_RESP;
					end else begin
						flags_q[w_q] <= 1'b1;
						fcnt_q       <= fcnt_new;
						if (fcnt_new >= n_eff) begin
							r_quit_q <= 1'b1;
							state_q  <= S_RESP;
						end else begin
							ip_q      <= '0;
							rd_vld_s1 <= 1'b0;
							state_q   <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					ip_q      <= ip_q + 1'b1;
					rd_vld_s1 <= (ip_q < n_eff) && !scan_end;
					if (rd_vld_s1 && !self_hit) begin
						peer_q <= rd_addr_s1;
						pf_q   <= rd_front;
						pb_q   <= rd_back;
					end
					if (scan_end) begin
						state_q <= S_STEAL;
					end
				end
				S_STEAL: begin
					r_start_q <= st_b;
					r_stop_q  <= pb_q;
					r_has_q   <= (st_b < pb_q);
					r_peer_q  <= 1'b1;
					r_idx_q   <= peer_q;
					state_q   <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						out_valid   <= 1'b1;
						range_start <= r_start_q;
						range_stop  <= r_stop_q;
						has_work    <= r_has_q;
						from_peer   <= r_peer_q;
						peer_index  <= r_idx_q;
						quit        <= r_quit_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_addr_s1 <= ram_raddr;
		end
	end
endmodule
`default_nettype wire

/* verif/testbench.sv */
// Testbench for the work-stealing range dispatcher: random transactions against a predictor.
`timescale 1ns / 100ps

module testbench
	import wsrd_pkg::*;
();

	localparam int SETTLE_CYCLES = 60;
	localparam int RANDOM_ITEMS  = 420;

	typedef struct packed {
		task_t               start_idx;
		task_t               stop_idx;
		logic                has_work;
		logic                from_peer;
		logic [WID_BITS-1:0] peer;
		logic                quit;
	} grant_t;

	class grant_tracker;
		logic [4:0]             workers_cfg;
		task_t                  total_cfg;
		task_t                  front [MAX_WORKERS];
		task_t                  back [MAX_WORKERS];
		logic [MAX_WORKERS-1:0] finished;
		int unsigned            finished_cnt;
		grant_t                 grants_due [$];
		int unsigned            errors;

		function new();
			workers_cfg = 5'd1;
			total_cfg = '0;
			foreach (front[i]) begin
				front[i] = '0;
				back[i] = '0;
			end
			finished = '0;
			finished_cnt = 0;
			errors = 0;
		endfunction

		function void set_reg(logic idx, task_t val);
			if (idx == CFG_NUM_WORKERS) begin
				workers_cfg = val[4:0];
			end else begin
				total_cfg = val;
			end
		endfunction

		function int unsigned active_workers();
			int unsigned n;
			n = workers_cfg;
			if (n == 0) n = 1;
			if (n > MAX_WORKERS) n = MAX_WORKERS;
			return n;
		endfunction

		function void split_range();
			longint unsigned n, t, per, b, e;
			n = active_workers();
			t = total_cfg;
			per = (t + n - 1) / n;
			for (int i = 0; i < MAX_WORKERS; i++) begin
				if (i < n) begin
					b = i * per;
					e = b + per;
					if (b > t) b = t;
					if (e > t) e = t;
					front[i] = task_t'(b);
					back[i] = task_t'(e);
				end else begin
					front[i] = '0;
					back[i] = '0;
				end
			end
			finished = '0;
			finished_cnt = 0;
		endfunction

		function grant_t dispatch(logic c, logic [WID_BITS-1:0] w);
			grant_t          g;
			int unsigned     n, wi, peer;
			bit              found;
			longint unsigned b, e, fr, bk;
			g = '0;
			if (c == CMD_START) begin
				split_range();
				return g;
			end
			n = active_workers();
			wi = w;
			if (wi >= n) begin
				g.quit = 1'b1;
				return g;
			end
			if (front[wi] < back[wi]) begin
				b = front[wi];
				e = b + BURST;
				if (e > back[wi]) e = back[wi];
				front[wi] = task_t'(e);
				g.start_idx = task_t'(b);
				g.stop_idx = task_t'(e);
				g.has_work = 1'b1;
				return g;
			end
			if (!finished[wi]) begin
				finished[wi] = 1'b1;
				finished_cnt++;
			end
			if (finished_cnt >= n) begin
				g.quit = 1'b1;
				return g;
			end
			peer = 0;
			found = 1'b0;
			for (int unsigned ip = 0; ip < n && !found; ip++) begin
				if (ip != wi) begin
					peer = ip;
					fr = front[ip];
					bk = back[ip];
					if (fr + BURST < bk) found = 1'b1;
				end
			end
			e = back[peer];
			b = (e > BURST) ? e - BURST : 0;
			if (b < front[peer]) b = front[peer];
			back[peer] = task_t'(b);
			g.start_idx = task_t'(b);
			g.stop_idx = task_t'(e);
			g.has_work = (b < e);
			g.from_peer = 1'b1;
			g.peer = WID_BITS'(peer);
			return g;
		endfunction

		function void note_request(logic c, logic [WID_BITS-1:0] w);
			grants_due.push_back(dispatch(c, w));
		endfunction

		function int unsigned pending();
			return grants_due.size();
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			errors++;
		endtask

		task check_grant(grant_t got);
			grant_t want;
			if (grants_due.size() == 0) begin
				report($sformatf("result with no request pending: %p", got));
				return;
			end
			want = grants_due.pop_front();
			if (got.start_idx !== want.start_idx)
				report($sformatf("range_start %0d, want %0d", got.start_idx, want.start_idx));
			if (got.stop_idx !== want.stop_idx)
				report($sformatf("range_stop %0d, want %0d", got.stop_idx, want.stop_idx));
			if (got.has_work !== want.has_work)
				report($sformatf("has_work %b, want %b", got.has_work, want.has_work));
			if (got.from_peer !== want.from_peer)
				report($sformatf("from_peer %b, want %b", got.from_peer, want.from_peer));
			if (got.peer !== want.peer)
				report($sformatf("peer_index %0d, want %0d", got.peer, want.peer));
			if (got.quit !== want.quit)
				report($sformatf("quit %b, want %b", got.quit, want.quit));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_wen;
	logic                cfg_index;
	logic [TASK_BITS-1:0] cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic                cmd;
	logic [WID_BITS-1:0] worker_id;
	logic                out_valid;
	logic                out_ready;
	logic [TASK_BITS-1:0] range_start;
	logic [TASK_BITS-1:0] range_stop;
	logic                has_work;
	logic                from_peer;
	logic [WID_BITS-1:0] peer_index;
	logic                quit;

	grant_tracker grants;
	int unsigned  send_idle_pct;
	int unsigned  recv_stall_pct;
	int unsigned  hold_req;
	int unsigned  items_sent;

	work_stealing_range_dispatcher_core i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic send_item(input logic c, input logic [WID_BITS-1:0] w);
		int unsigned gap;
		gap = 0;
		while (gap < 200 && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		worker_id <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		grants.note_request(c, w);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (grants.pending() != 0) @(posedge clk);
	endtask

	task automatic configure(input logic [4:0] nw, input task_t tt);
		drain();
		repeat (4) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= CFG_NUM_WORKERS;
		cfg_data  <= task_t'(nw);
		@(posedge clk);
		cfg_index <= CFG_TOTAL_TASKS;
		cfg_data  <= tt;
		@(posedge clk);
		cfg_wen <= 1'b0;
		grants.set_reg(CFG_NUM_WORKERS, task_t'(nw));
		grants.set_reg(CFG_TOTAL_TASKS, tt);
	endtask

	initial begin
		grant_t got;
		int unsigned hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = '{range_start, range_stop, has_work, from_peer, peer_index, quit};
				grants.check_grant(got);
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int unsigned phase, len, r, n_eff;
		logic [4:0]  nw;
		task_t       tt;
		cfg_wen   <= 1'b0;
		cfg_index <= CFG_NUM_WORKERS;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		cmd       <= CMD_START;
		worker_id <= '0;
		arst_n    <= 1'b0;
		grants = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 0;
		items_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// requests before any start, then an out-of-range worker
		send_item(CMD_REQ, 0);
		send_item(CMD_REQ, 15);
		configure(5'd0, '0);
		send_item(CMD_START, 0);
		send_item(CMD_REQ, 0);
		configure(5'd4, 24'd100);
		send_item(CMD_START, 7);
		send_item(CMD_REQ, 0);
		send_item(CMD_REQ, 0);
		send_item(CMD_REQ, 3);
		send_item(CMD_REQ, 1);
		send_item(CMD_REQ, 2);
		configure(5'd31, 24'hFFFFFF);
		send_item(CMD_START, 0);
		send_item(CMD_REQ, 15);
		send_item(CMD_REQ, 15);
		send_item(CMD_REQ, 0);
		// own drain, steal, empty steal, then everyone finished
		configure(5'd2, 24'd40);
		send_item(CMD_START, 0);
		send_item(CMD_REQ, 0);
		send_item(CMD_REQ, 0);
		send_item(CMD_REQ, 0);
		send_item(CMD_REQ, 1);
		// worker count raised without a new start
		configure(5'd3, 24'd40);
		send_item(CMD_REQ, 2);
		send_item(CMD_REQ, 1);

		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 85;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 85;
				end
				default: begin
					send_idle_pct = 16;
					recv_stall_pct = 16;
				end
			endcase
			r = $urandom_range(9);
			if (r == 0) nw = 5'($urandom_range(31, 17));
			else if (r == 1) nw = 5'd0;
			else nw = 5'($urandom_range(16, 1));
			n_eff = (nw == 0) ? 1 : (nw > MAX_WORKERS) ? MAX_WORKERS : nw;
			r = $urandom_range(9);
			if (r == 0) tt = task_t'($urandom_range(24'hFFFFFF));
			else if (r == 1) tt = '0;
			else if (r == 2) tt = 24'hFFFFFF;
			else tt = task_t'($urandom_range(80 * n_eff));
			configure(nw, tt);
			if (phase == 4) hold_req = 300;
			if ($urandom_range(7) != 0) send_item(CMD_START, WID_BITS'($urandom_range(15)));
			len = $urandom_range(40, 10);
			for (int unsigned k = 0; k < len; k++) begin
				if (phase == 3 && k == len / 2) drain();
				r = $urandom_range(99);
				if (r < 3) send_item(CMD_START, WID_BITS'($urandom_range(15)));
				else if (r < 12) send_item(CMD_REQ, WID_BITS'($urandom_range(15)));
				else send_item(CMD_REQ, WID_BITS'($urandom_range(n_eff - 1)));
			end
			phase++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (grants.errors == 0 && grants.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
